### src/rbad_pkg.sv
// ----------------------------------------------------------------------------
// rbad_pkg
// Shared types and constants of the bulk array deframer: item structs, byte
// classes, parser phases, result kinds, error codes and limits.
// ----------------------------------------------------------------------------
package rbad_pkg;

   localparam int LEN_BITS    = 31;
   localparam int ACC_W       = 32;
   localparam int CNT_W       = 21;
   localparam int POS_W       = 20;
   localparam int MAX_ARR_W   = 21;
   localparam int MAX_BULK_W  = 31;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [MAX_ARR_W-1:0]  ARRAY_CAP      = MAX_ARR_W'(1048576);
   localparam logic [ACC_W-1:0]      BULK_CAP       = ACC_W'((64'd1 << LEN_BITS) - 64'd1);
   localparam logic [MAX_ARR_W-1:0]  MAX_ARR_RESET  = MAX_ARR_W'(1024);
   localparam logic [MAX_BULK_W-1:0] MAX_BULK_RESET = MAX_BULK_W'(536870912);

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ARRAY_LEN = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BULK_LEN  = CSR_IDX_W'(1);

   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_STAR,
      CLS_DOLLAR,
      CLS_MINUS,
      CLS_PLUS,
      CLS_DIGIT,
      CLS_CR,
      CLS_LF
   } byte_class_type;

   typedef enum logic [3:0] {
      PH_STAR      = 4'd0,
      PH_ALEN_HEAD = 4'd1,
      PH_ALEN_BODY = 4'd2,
      PH_ALEN_LF   = 4'd3,
      PH_DOLLAR    = 4'd4,
      PH_BLEN_HEAD = 4'd5,
      PH_BLEN_BODY = 4'd6,
      PH_BLEN_LF   = 4'd7,
      PH_PAYLOAD   = 4'd8,
      PH_DATA_CR   = 4'd9,
      PH_DATA_LF   = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_ELEM_END = 2'd1,
      KIND_EMPTY    = 2'd2,
      KIND_ERROR    = 2'd3
   } out_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_BAD_LEAD   = 3'd1,
      ERR_BAD_DIGITS = 3'd2,
      ERR_OVER_LIMIT = 3'd3,
      ERR_NO_CRLF    = 3'd4
   } err_code_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       conn_start;
   } req_type;

   typedef struct packed {
      out_kind_type     out_kind;
      logic [7:0]       out_byte;
      logic [POS_W-1:0] elem_index;
      logic             last_element;
      err_code_type     err_code;
   } rsp_type;

   typedef struct packed {
      logic [7:0]     in_byte;
      logic           conn_start;
      byte_class_type cls;
      logic [3:0]     digit;
   } token_type;

endpackage

### src/resp_bulk_array_deframer_core.sv
// An accepted byte is written into the item queue; its item is then held in the result register.
// Throughput: one byte per cycle; the parser takes one queued byte a cycle while not stalled.
// A four-entry queue lets the input run ahead while the result is stalled.
// Reset is synchronous and active high: the parser returns to statement start,
// the queue and result register empty, and the limits take their reset values.
// ----------------------------------------------------------------------------
// resp_bulk_array_deframer_core
// Top level of the bulk array deframer: classifier, item queue and parser.
// ----------------------------------------------------------------------------
module resp_bulk_array_deframer_core import rbad_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   token_type token;
   token_type head;
   logic      empty;
   logic      full;
   logic      pop;

   assign req_stall = full;
   assign csr_ready = 1'b1;

   rbad_front u_front (
      .req_data (req_data),
      .token    (token)
   );

   rbad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (token),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   rbad_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### src/rbad_front.sv
// ----------------------------------------------------------------------------
// rbad_front
// Byte classifier: sorts each incoming byte into the lexical class that the
// parser needs and extracts its decimal digit value.
// ----------------------------------------------------------------------------
module rbad_front import rbad_pkg::*; (
   input  req_type   req_data,
   output token_type token
);

   logic [7:0] b;
   logic [7:0] digit_full;

   assign b          = req_data.in_byte;
   assign digit_full = b - CH_ZERO;

   always_comb begin
      token.in_byte    = b;
      token.conn_start = req_data.conn_start;
      token.digit      = digit_full[3:0];
      if (b >= CH_ZERO && b <= CH_NINE) begin
         token.cls = CLS_DIGIT;
      end else begin
         unique case (b)
            CH_STAR:   token.cls = CLS_STAR;
            CH_DOLLAR: token.cls = CLS_DOLLAR;
            CH_MINUS:  token.cls = CLS_MINUS;
            CH_PLUS:   token.cls = CLS_PLUS;
            CH_CR:     token.cls = CLS_CR;
            CH_LF:     token.cls = CLS_LF;
            default:   token.cls = CLS_OTHER;
         endcase
      end
   end

endmodule

### src/rbad_queue.sv
// ----------------------------------------------------------------------------
// rbad_queue
// Small FIFO of classified items between the classifier and the parser.
// ----------------------------------------------------------------------------
module rbad_queue import rbad_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_data,
   input  logic      pop,
   output token_type head,
   output logic      empty,
   output logic      full
);

   token_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QCNT_W'(QDEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/rbad_back.sv
// ----------------------------------------------------------------------------
// rbad_back
// Statement parser: walks the framing of each statement one classified item
// at a time, holds the limit registers and drives the registered result.
// ----------------------------------------------------------------------------
module rbad_back import rbad_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  token_type             head,
   input  logic                  empty,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   logic [MAX_ARR_W-1:0]  max_arr_ff, max_arr_in;
   logic [MAX_BULK_W-1:0] max_bulk_ff, max_bulk_in;

   phase_type            phase_ff, phase_in, phase_nxt;
   logic [ACC_W-1:0]     acc_ff, acc_in, acc_nxt;
   logic                 neg_ff, neg_in, neg_nxt;
   logic                 hd_ff, hd_in, hd_nxt;
   logic [CNT_W-1:0]     left_ff, left_in, left_nxt;
   logic [POS_W-1:0]     pos_ff, pos_in, pos_nxt;
   logic [LEN_BITS-1:0]  pay_ff, pay_in, pay_nxt;
   logic                 lock_ff, lock_in, lock_nxt;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_data_ff, out_data_in;

   phase_type            e_phase;
   logic [ACC_W-1:0]     e_acc;
   logic                 e_neg, e_hd, e_lock;
   logic [CNT_W-1:0]     e_left;
   logic [POS_W-1:0]     e_pos;
   logic [LEN_BITS-1:0]  e_pay;

   logic                 advance;
   logic                 res_valid;
   rsp_type              res;
   logic [ACC_W+3:0]     acc_wide;
   logic [ACC_W-1:0]     acc_sat;
   logic [MAX_ARR_W-1:0] arr_lim;
   logic [ACC_W-1:0]     bulk_lim;
   logic                 acc_zero, over_arr, over_bulk;
   logic [CNT_W-1:0]     left_dec;
   logic [LEN_BITS-1:0]  pay_dec;
   logic                 head_phase, sign_ok, len_cr_ok;
   phase_type            body_ph, lf_ph, done_ph;

   assign advance = !out_valid_ff || !rsp_stall;
   assign pop     = advance && !empty;

   // A restart request clears the parser before the byte is looked at.
   assign e_phase = head.conn_start ? PH_STAR : phase_ff;
   assign e_acc   = head.conn_start ? '0 : acc_ff;
   assign e_neg   = head.conn_start ? 1'b0 : neg_ff;
   assign e_hd    = head.conn_start ? 1'b0 : hd_ff;
   assign e_left  = head.conn_start ? '0 : left_ff;
   assign e_pos   = head.conn_start ? '0 : pos_ff;
   assign e_pay   = head.conn_start ? '0 : pay_ff;
   assign e_lock  = head.conn_start ? 1'b0 : lock_ff;

   assign acc_wide = {1'b0, e_acc, 3'b000} + {3'b000, e_acc, 1'b0} +
                     (ACC_W+4)'(head.digit);
   assign acc_sat  = (acc_wide[ACC_W+3:ACC_W] != '0) ? '1 : acc_wide[ACC_W-1:0];
   assign arr_lim  = (max_arr_ff > ARRAY_CAP) ? ARRAY_CAP : max_arr_ff;
   assign bulk_lim = ({1'b0, max_bulk_ff} > BULK_CAP) ? BULK_CAP : {1'b0, max_bulk_ff};
   assign acc_zero  = (e_acc == '0);
   assign over_arr  = (e_acc > ACC_W'(arr_lim));
   assign over_bulk = (e_acc > bulk_lim);
   assign left_dec  = e_left - 1'b1;
   assign pay_dec   = e_pay - 1'b1;
   assign done_ph   = (left_dec == '0) ? PH_STAR : PH_DOLLAR;

   assign head_phase = (e_phase == PH_ALEN_HEAD) || (e_phase == PH_BLEN_HEAD);
   assign sign_ok    = head_phase && (head.cls == CLS_MINUS || head.cls == CLS_PLUS);
   assign len_cr_ok  = (head.cls == CLS_CR) && e_hd;
   assign body_ph    = (e_phase == PH_ALEN_HEAD || e_phase == PH_ALEN_BODY) ?
                       PH_ALEN_BODY : PH_BLEN_BODY;
   assign lf_ph      = (e_phase == PH_ALEN_HEAD || e_phase == PH_ALEN_BODY) ?
                       PH_ALEN_LF : PH_BLEN_LF;

   always_comb begin
      phase_nxt = e_phase;
      if (!e_lock) begin
         unique case (e_phase)
            PH_STAR: begin
               if (head.cls == CLS_STAR) begin
                  phase_nxt = PH_ALEN_HEAD;
               end
            end
            PH_ALEN_HEAD, PH_ALEN_BODY, PH_BLEN_HEAD, PH_BLEN_BODY: begin
               if (sign_ok || head.cls == CLS_DIGIT) begin
                  phase_nxt = body_ph;
               end else if (len_cr_ok) begin
                  phase_nxt = lf_ph;
               end
            end
            PH_ALEN_LF: begin
               if (head.cls == CLS_LF) begin
                  if (e_neg || acc_zero) begin
                     phase_nxt = PH_STAR;
                  end else if (!over_arr) begin
                     phase_nxt = PH_DOLLAR;
                  end
               end
            end
            PH_DOLLAR: begin
               if (head.cls == CLS_DOLLAR) begin
                  phase_nxt = PH_BLEN_HEAD;
               end
            end
            PH_BLEN_LF: begin
               if (head.cls == CLS_LF) begin
                  if (e_neg && !acc_zero) begin
                     phase_nxt = done_ph;
                  end else if (!over_bulk) begin
                     phase_nxt = acc_zero ? PH_DATA_CR : PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (pay_dec == '0) begin
                  phase_nxt = PH_DATA_CR;
               end
            end
            PH_DATA_CR: begin
               if (head.cls == CLS_CR) begin
                  phase_nxt = PH_DATA_LF;
               end
            end
            PH_DATA_LF: begin
               if (head.cls == CLS_LF) begin
                  phase_nxt = done_ph;
               end
            end
            default: phase_nxt = PH_STAR;
         endcase
      end
   end

   always_comb begin
      acc_nxt   = e_acc;
      neg_nxt   = e_neg;
      hd_nxt    = e_hd;
      left_nxt  = e_left;
      pos_nxt   = e_pos;
      pay_nxt   = e_pay;
      lock_nxt  = e_lock;
      res_valid = 1'b0;
      res       = '0;
      if (!e_lock) begin
         unique case (e_phase)
            PH_STAR, PH_DOLLAR: begin
               if ((e_phase == PH_STAR && head.cls == CLS_STAR) ||
                   (e_phase == PH_DOLLAR && head.cls == CLS_DOLLAR)) begin
                  acc_nxt = '0;
                  neg_nxt = 1'b0;
                  hd_nxt  = 1'b0;
               end else begin
                  lock_nxt     = 1'b1;
                  res_valid    = 1'b1;
                  res.out_kind = KIND_ERROR;
                  res.err_code = ERR_BAD_LEAD;
               end
            end
            PH_ALEN_HEAD, PH_ALEN_BODY, PH_BLEN_HEAD, PH_BLEN_BODY: begin
               if (sign_ok) begin
                  neg_nxt = (head.cls == CLS_MINUS);
               end else if (head.cls == CLS_DIGIT) begin
                  acc_nxt = acc_sat;
                  hd_nxt  = 1'b1;
               end else if (!len_cr_ok) begin
                  lock_nxt     = 1'b1;
                  res_valid    = 1'b1;
                  res.out_kind = KIND_ERROR;
                  res.err_code = ERR_BAD_DIGITS;
               end
            end
            PH_ALEN_LF: begin
               if (head.cls != CLS_LF) begin
                  lock_nxt     = 1'b1;
                  res_valid    = 1'b1;
                  res.out_kind = KIND_ERROR;
                  res.err_code = ERR_NO_CRLF;
               end else if (e_neg || acc_zero) begin
                  res_valid    = 1'b1;
                  res.out_kind = KIND_EMPTY;
               end else if (over_arr) begin
                  lock_nxt     = 1'b1;
                  res_valid    = 1'b1;
                  res.out_kind = KIND_ERROR;
                  res.err_code = ERR_OVER_LIMIT;
               end else begin
                  left_nxt = e_acc[CNT_W-1:0];
                  pos_nxt  = '0;
               end
            end
            PH_BLEN_LF: begin
               if (head.cls != CLS_LF) begin
                  lock_nxt     = 1'b1;
                  res_valid    = 1'b1;
                  res.out_kind = KIND_ERROR;
                  res.err_code = ERR_NO_CRLF;
               end else if (e_neg && !acc_zero) begin
                  left_nxt         = left_dec;
                  pos_nxt          = e_pos + 1'b1;
                  res_valid        = 1'b1;
                  res.out_kind     = KIND_ELEM_END;
                  res.elem_index   = e_pos;
                  res.last_element = (e_left == CNT_W'(1));
               end else if (over_bulk) begin
                  lock_nxt     = 1'b1;
                  res_valid    = 1'b1;
                  res.out_kind = KIND_ERROR;
                  res.err_code = ERR_OVER_LIMIT;
               end else begin
                  pay_nxt = e_acc[LEN_BITS-1:0];
               end
            end
            PH_PAYLOAD: begin
               pay_nxt        = pay_dec;
               res_valid      = 1'b1;
               res.out_kind   = KIND_PAYLOAD;
               res.out_byte   = head.in_byte;
               res.elem_index = e_pos;
            end
            PH_DATA_CR: begin
               if (head.cls != CLS_CR) begin
                  lock_nxt     = 1'b1;
                  res_valid    = 1'b1;
                  res.out_kind = KIND_ERROR;
                  res.err_code = ERR_NO_CRLF;
               end
            end
            PH_DATA_LF: begin
               if (head.cls != CLS_LF) begin
                  lock_nxt     = 1'b1;
                  res_valid    = 1'b1;
                  res.out_kind = KIND_ERROR;
                  res.err_code = ERR_NO_CRLF;
               end else begin
                  left_nxt         = left_dec;
                  pos_nxt          = e_pos + 1'b1;
                  res_valid        = 1'b1;
                  res.out_kind     = KIND_ELEM_END;
                  res.elem_index   = e_pos;
                  res.last_element = (e_left == CNT_W'(1));
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      phase_in     = pop ? phase_nxt : phase_ff;
      acc_in       = pop ? acc_nxt : acc_ff;
      neg_in       = pop ? neg_nxt : neg_ff;
      hd_in        = pop ? hd_nxt : hd_ff;
      left_in      = pop ? left_nxt : left_ff;
      pos_in       = pop ? pos_nxt : pos_ff;
      pay_in       = pop ? pay_nxt : pay_ff;
      lock_in      = pop ? lock_nxt : lock_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = pop && res_valid;
         out_data_in  = res;
      end
      max_arr_in  = max_arr_ff;
      max_bulk_in = max_bulk_ff;
      if (csr_valid && csr_index == CSR_MAX_ARRAY_LEN) begin
         max_arr_in = csr_data[MAX_ARR_W-1:0];
      end
      if (csr_valid && csr_index == CSR_MAX_BULK_LEN) begin
         max_bulk_in = csr_data[MAX_BULK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_STAR;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         hd_ff        <= 1'b0;
         left_ff      <= '0;
         pos_ff       <= '0;
         pay_ff       <= '0;
         lock_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         max_arr_ff   <= MAX_ARR_RESET;
         max_bulk_ff  <= MAX_BULK_RESET;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         hd_ff        <= hd_in;
         left_ff      <= left_in;
         pos_ff       <= pos_in;
         pay_ff       <= pay_in;
         lock_ff      <= lock_in;
         out_valid_ff <= out_valid_in;
         max_arr_ff   <= max_arr_in;
         max_bulk_ff  <= max_bulk_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### src/rbad_checker.sv
// ----------------------------------------------------------------------------
// rbad_checker
// Port-level checks of the bulk array deframer, bound to its top level.
// ----------------------------------------------------------------------------
module rbad_checker import rbad_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or vanished");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind != KIND_PAYLOAD |-> rsp_data.out_byte == 8'd0)
      else $error("byte field set on a non-payload item");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.out_kind == KIND_ERROR) == (rsp_data.err_code != ERR_NONE)))
      else $error("error code does not match item kind");

   a_last_elem: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_element |-> rsp_data.out_kind == KIND_ELEM_END)
      else $error("last element flag on an item that is not an element end");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind resp_bulk_array_deframer_core rbad_checker u_rbad_checker (.*);

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bulk array deframer core. Byte streams built
// from well-formed statements, broken statements and raw noise are driven
// under several limit settings, with random idling on both channels and one
// long result hold-off. Every accepted byte is run through a cycle-free
// predictor of the parser, and each result item is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
   import rbad_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 12;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   resp_bulk_array_deframer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   req_type         bytes_to_send[$];
   rsp_type         results_due[$];
   logic [7:0]      stmt_bytes[$];
   int unsigned     items_queued = 0;
   int unsigned     bytes_taken = 0;
   int unsigned     results_checked = 0;
   int unsigned     mismatches = 0;
   int unsigned     csr_writes = 0;
   int unsigned     quiet_cycles = 0;
   int unsigned     hold_left = 0;
   int unsigned     kinds_seen[4] = '{0, 0, 0, 0};
   bit              req_taken = 1'b0;
   bit              steady = 1'b0;
   bit              hold_request = 1'b0;

   // Parser image and limit registers.
   logic [MAX_ARR_W-1:0]  arr_limit = MAX_ARR_RESET;
   logic [MAX_BULK_W-1:0] bulk_limit = MAX_BULK_RESET;
   phase_type             parse_ph = PH_STAR;
   logic [ACC_W-1:0]      len_acc = '0;
   bit                    len_neg = 1'b0;
   bit                    len_seen = 1'b0;
   logic [CNT_W-1:0]      elems_left = '0;
   logic [POS_W-1:0]      elem_pos = '0;
   logic [LEN_BITS-1:0]   bytes_left = '0;
   bit                    locked = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_length();
      len_acc = '0;
      len_neg = 1'b0;
      len_seen = 1'b0;
   endfunction

   function automatic err_code_type length_step(logic [7:0] b, phase_type head,
                                                phase_type body, phase_type lf);
      logic [ACC_W+3:0] wide;
      if (parse_ph == head && (b == CH_MINUS || b == CH_PLUS)) begin
         len_neg = (b == CH_MINUS);
         parse_ph = body;
         return ERR_NONE;
      end
      if (b >= CH_ZERO && b <= CH_NINE) begin
         wide = (ACC_W + 4)'(len_acc) * 36'd10 + (ACC_W + 4)'(b - CH_ZERO);
         len_acc = (wide > 36'hFFFF_FFFF) ? '1 : wide[ACC_W-1:0];
         len_seen = 1'b1;
         parse_ph = body;
         return ERR_NONE;
      end
      if (b == CH_CR && len_seen) begin
         parse_ph = lf;
         return ERR_NONE;
      end
      return ERR_BAD_DIGITS;
   endfunction

   function automatic void close_element(output rsp_type res);
      res = '0;
      res.out_kind = KIND_ELEM_END;
      res.elem_index = elem_pos;
      res.last_element = (elems_left == 1);
      elems_left = elems_left - 1'b1;
      elem_pos = elem_pos + 1'b1;
      parse_ph = (elems_left == 0) ? PH_STAR : PH_DOLLAR;
   endfunction

   function automatic void deframe_byte(input req_type item, output bit emitted,
                                        output rsp_type res);
      logic [7:0]       b;
      logic [ACC_W-1:0] lim;
      err_code_type     code;
      b = item.in_byte;
      code = ERR_NONE;
      emitted = 1'b0;
      res = '0;
      if (item.conn_start) begin
         parse_ph = PH_STAR;
         clear_length();
         elems_left = '0;
         elem_pos = '0;
         bytes_left = '0;
         locked = 1'b0;
      end
      if (locked)
         return;
      case (parse_ph)
         PH_STAR: begin
            if (b != CH_STAR) begin
               code = ERR_BAD_LEAD;
            end else begin
               clear_length();
               parse_ph = PH_ALEN_HEAD;
            end
         end
         PH_ALEN_HEAD, PH_ALEN_BODY: begin
            code = length_step(b, PH_ALEN_HEAD, PH_ALEN_BODY, PH_ALEN_LF);
         end
         PH_ALEN_LF: begin
            lim = ACC_W'((arr_limit > ARRAY_CAP) ? ARRAY_CAP : arr_limit);
            if (b != CH_LF) begin
               code = ERR_NO_CRLF;
            end else if (len_neg || len_acc == 0) begin
               parse_ph = PH_STAR;
               emitted = 1'b1;
               res.out_kind = KIND_EMPTY;
            end else if (len_acc > lim) begin
               code = ERR_OVER_LIMIT;
            end else begin
               elems_left = len_acc[CNT_W-1:0];
               elem_pos = '0;
               parse_ph = PH_DOLLAR;
            end
         end
         PH_DOLLAR: begin
            if (b != CH_DOLLAR) begin
               code = ERR_BAD_LEAD;
            end else begin
               clear_length();
               parse_ph = PH_BLEN_HEAD;
            end
         end
         PH_BLEN_HEAD, PH_BLEN_BODY: begin
            code = length_step(b, PH_BLEN_HEAD, PH_BLEN_BODY, PH_BLEN_LF);
         end
         PH_BLEN_LF: begin
            lim = (ACC_W'(bulk_limit) > BULK_CAP) ? BULK_CAP : ACC_W'(bulk_limit);
            if (b != CH_LF) begin
               code = ERR_NO_CRLF;
            end else if (len_neg && len_acc != 0) begin
               close_element(res);
               emitted = 1'b1;
            end else if (len_acc > lim) begin
               code = ERR_OVER_LIMIT;
            end else begin
               bytes_left = len_acc[LEN_BITS-1:0];
               parse_ph = (bytes_left == 0) ? PH_DATA_CR : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0)
               parse_ph = PH_DATA_CR;
            emitted = 1'b1;
            res.out_kind = KIND_PAYLOAD;
            res.out_byte = b;
            res.elem_index = elem_pos;
         end
         PH_DATA_CR: begin
            if (b != CH_CR)
               code = ERR_NO_CRLF;
            else
               parse_ph = PH_DATA_LF;
         end
         PH_DATA_LF: begin
            if (b != CH_LF) begin
               code = ERR_NO_CRLF;
            end else begin
               close_element(res);
               emitted = 1'b1;
            end
         end
         default: begin
            parse_ph = PH_STAR;
         end
      endcase
      if (code != ERR_NONE) begin
         locked = 1'b1;
         emitted = 1'b1;
         res = '0;
         res.out_kind = KIND_ERROR;
         res.err_code = code;
      end
   endfunction

   function automatic string show_result(rsp_type r);
      return $sformatf("kind=%0d byte=%02h index=%0d last=%0d err=%0d", r.out_kind,
                       r.out_byte, r.elem_index, r.last_element, r.err_code);
   endfunction

   function automatic void add_byte(logic [7:0] v);
      stmt_bytes = {stmt_bytes, v};
   endfunction

   // In statement text, '<' stands for CR and '>' for LF.
   function automatic void add_text(string t);
      for (int i = 0; i < t.len(); i++) begin
         if (t[i] == "<")
            add_byte(CH_CR);
         else if (t[i] == ">")
            add_byte(CH_LF);
         else
            add_byte(8'(t[i]));
      end
   endfunction

   function automatic string len_text(int unsigned v, bit neg);
      string s;
      s = $sformatf("%0d", v);
      if ($urandom_range(9) == 0)
         s = {"0", s};
      if (neg)
         s = {"-", s};
      else if ($urandom_range(9) == 0)
         s = {"+", s};
      return s;
   endfunction

   function automatic void flush_stmt(int restart_at);
      req_type item;
      foreach (stmt_bytes[i]) begin
         item.in_byte = stmt_bytes[i];
         item.conn_start = (i == restart_at);
         bytes_to_send = {bytes_to_send, item};
      end
      items_queued += stmt_bytes.size();
      stmt_bytes.delete();
   endfunction

   function automatic void send_text(string t, int restart_at);
      add_text(t);
      flush_stmt(restart_at);
   endfunction

   function automatic void add_random_traffic(int unsigned amount, int unsigned max_count,
                                              int unsigned max_len);
      int unsigned      stop_at;
      int unsigned      n;
      int unsigned      len;
      int unsigned      roll;
      int               restart_at;
      bit               risky;
      string            count_text;
      logic [ACC_W-1:0] arr_eff;
      stop_at = items_queued + amount;
      arr_eff = ACC_W'((arr_limit > ARRAY_CAP) ? ARRAY_CAP : arr_limit);
      risky = 1'b1;
      while (items_queued < stop_at) begin
         restart_at = (risky || $urandom_range(19) == 0) ? 0 : -1;
         risky = 1'b0;
         roll = $urandom_range(99);
         if (roll < 4) begin
            repeat ($urandom_range(1, 6))
               add_byte(8'($urandom_range(255)));
            risky = 1'b1;
         end else if (roll < 10) begin
            count_text = (roll < 7) ? len_text($urandom(), 1'b1) : len_text(0, 1'b0);
            add_text({"*", count_text, "<>"});
         end else begin
            n = $urandom_range(1, max_count);
            risky = (n > arr_eff);
            add_text({"*", len_text(n, 1'b0), "<>"});
            repeat (n) begin
               if ($urandom_range(99) < 8) begin
                  add_text({"$", len_text($urandom_range(1, 20), 1'b1), "<>"});
               end else begin
                  len = $urandom_range(max_len);
                  if (len > bulk_limit)
                     risky = 1'b1;
                  add_text({"$", len_text(len, 1'b0), "<>"});
                  repeat (len)
                     add_byte(8'($urandom_range(255)));
                  add_text("<>");
               end
            end
         end
         roll = $urandom_range(99);
         if (roll < 10) begin
            stmt_bytes[$urandom_range(stmt_bytes.size() - 1)] = 8'($urandom_range(255));
            risky = 1'b1;
         end else if (roll < 14) begin
            restart_at = $urandom_range(stmt_bytes.size() - 1);
            risky = 1'b1;
         end
         flush_stmt(restart_at);
      end
   endfunction

   task automatic write_limit(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MAX_ARRAY_LEN)
         arr_limit = value[MAX_ARR_W-1:0];
      else
         bulk_limit = value[MAX_BULK_W-1:0];
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic finish_phase();
      while (bytes_taken != items_queued || results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (bytes_to_send.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
            req_data <= bytes_to_send.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 28);
      end
   end

   always @(posedge clock) begin
      bit      rsp_taken;
      bit      csr_taken;
      bit      emitted;
      rsp_type predicted;
      rsp_type want;
      rsp_type got;
      req_taken = !reset && req_valid && !req_stall;
      rsp_taken = !reset && rsp_valid && !rsp_stall;
      csr_taken = !reset && csr_valid && csr_ready;
      if (req_taken) begin
         bytes_taken++;
         deframe_byte(req_data, emitted, predicted);
         if (emitted)
            results_due = {results_due, predicted};
      end
      if (rsp_taken) begin
         got = rsp_data;
         kinds_seen[got.out_kind]++;
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result item with none expected: %s", show_result(got));
         end else begin
            want = results_due.pop_front();
            results_checked++;
            if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
                got.elem_index !== want.elem_index ||
                got.last_element !== want.last_element ||
                got.err_code !== want.err_code) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: result item mismatch: expected %s, got %s",
                           show_result(want), show_result(got));
            end
         end
      end
      if (req_taken || rsp_taken || csr_taken)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("ERROR: no item moved for %0d cycles", QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_text("*2<>$3<>abc<>$0<><>", 0);
      send_text("*0<>", -1);
      send_text("*-1<>", -1);
      send_text("*-0<>", -1);
      send_text("*+1<>$-1<>", -1);
      send_text("*1<>$-0<><>", -1);
      add_text("*3<>$2<>");
      add_byte(8'h00);
      add_byte(8'hFF);
      send_text("<>$-7<>$1<>z<>", -1);
      send_text("*-99999999999<>", -1);
      send_text("*1<>$-99999999999<>", -1);
      send_text("$1<>", -1);
      send_text("*0<>", -1);
      send_text("*x", 0);
      send_text("*<", 0);
      send_text("*-<", 0);
      send_text("*1-", 0);
      send_text("*+-", 0);
      send_text("*1<X", 0);
      send_text("*1<>$2<>abX", 0);
      send_text("*1<>$2<>ab<X", 0);
      send_text("*1<>#", 0);
      send_text("*99999999999<>", 0);
      send_text("*1<>$99999999999<>", 0);
      send_text("*1025<>", 0);
      send_text("*1024<>$1<>q<>", 0);
      finish_phase();

      write_limit(CSR_MAX_ARRAY_LEN, 32'd3);
      write_limit(CSR_MAX_BULK_LEN, 32'd5);
      add_random_traffic(200, 4, 6);
      finish_phase();

      write_limit(CSR_MAX_ARRAY_LEN, 32'd0);
      write_limit(CSR_MAX_BULK_LEN, 32'd0);
      send_text("*1<>", 0);
      send_text("*0<>", 0);
      send_text("*-3<>", -1);
      finish_phase();

      write_limit(CSR_MAX_ARRAY_LEN, 32'd1048576);
      send_text("*1<>$0<><>", 0);
      send_text("*1<>$1<>", -1);
      send_text("*1048577<>", 0);
      send_text("*1048576<>#", 0);
      add_random_traffic(100, 5, 2);
      finish_phase();

      write_limit(CSR_MAX_ARRAY_LEN, 32'hFFFF_FFFF);
      write_limit(CSR_MAX_BULK_LEN, 32'hFFFF_FFFF);
      send_text("*1048577<>", 0);
      send_text("*1<>$2147483647<>", 0);
      send_text("*1<>$2147483648<>", 0);
      hold_request = 1'b1;
      add_random_traffic(220, 6, 12);
      finish_phase();

      write_limit(CSR_MAX_ARRAY_LEN, 32'hFFE0_0400);
      write_limit(CSR_MAX_BULK_LEN, 32'd16);
      steady = 1'b1;
      add_random_traffic(220, 5, 20);
      finish_phase();

      $display("Deframed %0d bytes under %0d limit writes; %0d result items checked.",
               bytes_taken, csr_writes, results_checked);
      $display("Seen: %0d payload bytes, %0d element ends, %0d empty statements, %0d errors.",
               kinds_seen[KIND_PAYLOAD], kinds_seen[KIND_ELEM_END], kinds_seen[KIND_EMPTY],
               kinds_seen[KIND_ERROR]);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
